/* rtl/kaa_pkg.sv */
// Shared types and constants of the k-means assignment and update block.
// Used by the interfaces, the controller, the datapath and the top level.
package kaa_pkg;

  localparam int MAX_CLUSTERS = 256;
  localparam int MAX_DIMS     = 256;
  localparam int CL_W         = $clog2(MAX_CLUSTERS);
  localparam int DM_W         = $clog2(MAX_DIMS);
  localparam int CA_W         = CL_W + DM_W;
  localparam int CENT_DEPTH   = MAX_CLUSTERS * MAX_DIMS;
  localparam int CFG_W        = 9;
  localparam int SUM_W        = 24;
  localparam int CNT_W        = 16;
  localparam int DIST_W       = 24;

  localparam logic [CFG_W-1:0] NC_RESET = CFG_W'(MAX_CLUSTERS);
  localparam logic [CFG_W-1:0] ND_RESET = 9'd196;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLUSTERS = 2'd0;
  localparam logic [1:0] CFG_DIMS     = 2'd1;
  localparam logic [1:0] CFG_ACCUM    = 2'd2;

  typedef enum logic [2:0] {
    OP_LOAD_CENT  = 3'd0,
    OP_LOAD_LABEL = 3'd1,
    OP_POINT      = 3'd2,
    OP_UPDATE     = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [CL_W-1:0] c;
    logic [DM_W-1:0] d;
    logic [7:0]      value;
    kind_e           out_kind;
    logic            rd;
    logic            cent_ld;
    logic            lbl_ld;
    logic            pt_ld;
    logic            dist_clr;
    logic            dist_acc;
    logic            best_upd;
    logic            ovf_set;
    logic            sum_wr;
    logic            cnt_wr;
    logic            div_start;
    logic            cent_upd;
    logic            chg_clr;
    logic            rows_clr;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic [CL_W-1:0] best_c;
    logic            cnt_zero;
    logic            cnt_full;
    logic            div_done;
    logic            out_free;
  } sts_t;

endpackage

/* rtl/kaa_if.sv */
// Handshake channel interfaces of the k-means block: input items, result
// items and configuration writes. Depends on kaa_pkg for field widths.
interface kaa_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] cluster_index;
  logic [7:0] dim_index;
  logic [7:0] value;
  modport source (output valid, opcode, cluster_index, dim_index, value, input ready);
  modport sink   (input valid, opcode, cluster_index, dim_index, value, output ready);
endinterface

interface kaa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  nearest_cluster;
  logic [23:0] min_distance;
  logic [3:0]  cluster_label;
  logic        any_changed;
  logic        count_overflow;
  logic [7:0]  read_data;
  modport source (output valid, result_kind, nearest_cluster, min_distance, cluster_label,
                  any_changed, count_overflow, read_data, input ready);
  modport sink   (input valid, result_kind, nearest_cluster, min_distance, cluster_label,
                  any_changed, count_overflow, read_data, output ready);
endinterface

interface kaa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                index;
  logic [kaa_pkg::CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/kaa_div.sv */
// Restoring divider, one quotient bit per cycle, for the centroid update.
// Depends on kaa_pkg for the sum and count widths.
module kaa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kaa_pkg::SUM_W-1:0]   dividend_i,
  input  logic [kaa_pkg::CNT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [kaa_pkg::SUM_W-1:0]   quotient_o
);
  import kaa_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q, divisor_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W:0]    shifted, diffv;
  logic              ge;

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign ge      = shifted >= {1'b0, divisor_q};
  assign diffv   = shifted - {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diffv[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

/* rtl/kaa_dp.sv */
// Datapath: centroid, sum, count, label and point memories, the shared
// subtract-square-add unit, the divider and the result register.
// Depends on kaa_pkg, kaa_if and kaa_div.
module kaa_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kaa_pkg::cmd_t cmd_i,
  output kaa_pkg::sts_t sts_o,
  kaa_out_if.source     out_o
);
  import kaa_pkg::*;

  logic [7:0]       cent_mem [CENT_DEPTH];
  logic [SUM_W-1:0] sum_mem  [CENT_DEPTH];
  logic [7:0]       pb_mem   [MAX_DIMS];
  logic [CNT_W-1:0] cnt_mem  [MAX_CLUSTERS];
  logic [3:0]       lbl_mem  [MAX_CLUSTERS];
  logic [CFG_W-1:0] fill_mem [MAX_CLUSTERS];

  // A row whose valid bit is clear holds zero sums and a zero count.
  // In a valid row, sums at or beyond the row's fill length are zero as well.
  logic [MAX_CLUSTERS-1:0] row_vld_q;

  logic [CA_W-1:0]   addr;
  logic [7:0]        cent_rd_q, pb_rd_q;
  logic [SUM_W-1:0]  sum_rd_q, sum_eff;
  logic [CNT_W-1:0]  cnt_rd_q, cnt_eff;
  logic [3:0]        lbl_rd_q;
  logic              vld_rd_q;
  logic [CFG_W-1:0]  fill_rd_q, fill_eff, fill_nxt;
  logic [DM_W-1:0]   d_rd_q;
  logic              sum_hit;
  logic              cent_we;
  logic [7:0]        cent_wdata;

  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic [DIST_W-1:0]  acc_q, best_dist_q;
  logic [CL_W-1:0]    best_c_q;
  logic               changed_q, ovf_q, out_vld_q;

  logic              div_done;
  logic [SUM_W-1:0]  quotient;

  logic [1:0]        kind_q;
  logic [7:0]        near_q, rdat_q;
  logic [23:0]       dist_out_q;
  logic [3:0]        lbl_out_q;
  logic              chg_out_q, ovf_out_q;

  assign addr       = {cmd_i.c, cmd_i.d};
  assign fill_eff   = vld_rd_q ? fill_rd_q : '0;
  assign fill_nxt   = (({1'b0, cmd_i.d} + CFG_W'(1)) > fill_eff) ?
                      ({1'b0, cmd_i.d} + CFG_W'(1)) : fill_eff;
  assign sum_hit    = vld_rd_q && ({1'b0, d_rd_q} < fill_rd_q);
  assign sum_eff    = sum_hit ? sum_rd_q : '0;
  assign cnt_eff    = vld_rd_q ? cnt_rd_q : '0;
  assign cent_we    = cmd_i.cent_ld | cmd_i.cent_upd;
  assign cent_wdata = cmd_i.cent_ld ? cmd_i.value : quotient[7:0];
  assign diff       = $signed({1'b0, cent_rd_q}) - $signed({1'b0, pb_rd_q});
  assign prod       = diff * diff;

  kaa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_eff),
    .divisor_i  (cnt_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cent_we) cent_mem[addr] <= cent_wdata;
    if (cmd_i.rd) cent_rd_q <= cent_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_wr) sum_mem[addr] <= sum_eff + SUM_W'(pb_rd_q);
    if (cmd_i.rd) sum_rd_q <= sum_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_ld) pb_mem[cmd_i.d] <= cmd_i.value;
    if (cmd_i.rd) pb_rd_q <= pb_mem[cmd_i.d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_wr) cnt_mem[cmd_i.c] <= cnt_eff + CNT_W'(1);
    if (cmd_i.rd) cnt_rd_q <= cnt_mem[cmd_i.c];
  end

  // The count is written with the last coordinate, so the fill length grows to the point length.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_wr) fill_mem[cmd_i.c] <= fill_nxt;
    if (cmd_i.rd) begin
      fill_rd_q <= fill_mem[cmd_i.c];
      d_rd_q    <= cmd_i.d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lbl_ld) lbl_mem[cmd_i.c] <= cmd_i.value[3:0];
    if (cmd_i.rd) lbl_rd_q <= lbl_mem[cmd_i.c];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) vld_rd_q <= row_vld_q[cmd_i.c];
    if (cmd_i.dist_clr) begin
      acc_q <= '0;
    end else if (cmd_i.dist_acc) begin
      acc_q <= acc_q + DIST_W'(prod[15:0]);
    end else if (cmd_i.best_upd) begin
      acc_q <= '0;
    end
    // The first cluster always wins; later ones only on a strictly smaller distance.
    if (cmd_i.best_upd && (cmd_i.c == '0 || acc_q < best_dist_q)) begin
      best_dist_q <= acc_q;
      best_c_q    <= cmd_i.c;
    end
    if (cmd_i.out_load) begin
      kind_q     <= cmd_i.out_kind;
      near_q     <= '0;
      dist_out_q <= '0;
      lbl_out_q  <= '0;
      chg_out_q  <= 1'b0;
      ovf_out_q  <= 1'b0;
      rdat_q     <= '0;
      case (cmd_i.out_kind)
        KIND_ASSIGN: begin
          near_q     <= 8'(best_c_q);
          dist_out_q <= best_dist_q;
          lbl_out_q  <= lbl_rd_q;
        end
        KIND_UPDATE: begin
          chg_out_q <= changed_q;
          ovf_out_q <= ovf_q;
        end
        KIND_READ: begin
          rdat_q <= cent_rd_q;
        end
        default: begin
          rdat_q <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      changed_q <= 1'b0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.rows_clr) begin
        row_vld_q <= '0;
        ovf_q     <= 1'b0;
      end else begin
        if (cmd_i.cnt_wr) row_vld_q[cmd_i.c] <= 1'b1;
        if (cmd_i.ovf_set) ovf_q <= 1'b1;
      end
      if (cmd_i.chg_clr) begin
        changed_q <= 1'b0;
      end else if (cmd_i.cent_upd && quotient[7:0] != cent_rd_q) begin
        changed_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.best_c   = best_c_q;
  assign sts_o.cnt_zero = cnt_eff == '0;
  assign sts_o.cnt_full = cnt_eff == CNT_MAX;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_vld_q || out_o.ready;

  assign out_o.valid           = out_vld_q;
  assign out_o.result_kind     = kind_q;
  assign out_o.nearest_cluster = near_q;
  assign out_o.min_distance    = dist_out_q;
  assign out_o.cluster_label   = lbl_out_q;
  assign out_o.any_changed     = chg_out_q;
  assign out_o.count_overflow  = ovf_out_q;
  assign out_o.read_data       = rdat_q;
endmodule

/* rtl/kaa_ctrl.sv */
// Controller: takes input items, keeps the point byte position and walks
// the cluster and coordinate loops by issuing datapath commands.
// Depends on kaa_pkg and kaa_if.
module kaa_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kaa_in_if.sink                     in_i,
  input  logic [kaa_pkg::CFG_W-1:0]  nc_i,
  input  logic [kaa_pkg::CFG_W-1:0]  nd_i,
  input  logic                       acc_en_i,
  input  kaa_pkg::sts_t              sts_i,
  output kaa_pkg::cmd_t              cmd_o
);
  import kaa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIST_RD, S_DIST_EX, S_DIST_CMP, S_ACC_CHK_RD, S_ACC_CHK,
    S_ACC_RD, S_ACC_EX, S_UPD_CNT_RD, S_UPD_CNT, S_UPD_RD, S_UPD_DIV,
    S_UPD_WAIT, S_PUT
  } state_e;

  state_e          state_q;
  logic [CL_W-1:0] c_q;
  logic [DM_W-1:0] d_q, pos_q;
  kind_e           kind_q;
  logic            accept, last_d, last_c, last_pt;

  assign in_i.ready = state_q == S_IDLE;
  assign accept     = in_i.valid && in_i.ready;
  assign last_d     = {1'b0, d_q} == nd_i - CFG_W'(1);
  assign last_c     = {1'b0, c_q} == nc_i - CFG_W'(1);
  // A byte completes the point once its position is the last one of the current length, or beyond it.
  assign last_pt    = {1'b0, pos_q} + CFG_W'(1) >= nd_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.c        = c_q;
    cmd_o.d        = d_q;
    cmd_o.value    = in_i.value;
    cmd_o.out_kind = kind_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.c = in_i.cluster_index;
          cmd_o.d = in_i.dim_index;
          case (op_e'(in_i.opcode))
            OP_LOAD_CENT:  cmd_o.cent_ld = 1'b1;
            OP_LOAD_LABEL: cmd_o.lbl_ld  = 1'b1;
            OP_POINT: begin
              cmd_o.d        = pos_q;
              cmd_o.pt_ld    = 1'b1;
              cmd_o.dist_clr = last_pt;
            end
            OP_UPDATE:     cmd_o.chg_clr = 1'b1;
            OP_READ:       cmd_o.rd      = 1'b1;
            default:       cmd_o.rd      = 1'b0;
          endcase
        end
      end
      S_DIST_RD, S_ACC_RD, S_UPD_CNT_RD, S_UPD_RD: cmd_o.rd = 1'b1;
      S_DIST_EX:  cmd_o.dist_acc = 1'b1;
      S_DIST_CMP: cmd_o.best_upd = 1'b1;
      S_ACC_CHK_RD: begin
        cmd_o.c  = sts_i.best_c;
        cmd_o.rd = 1'b1;
      end
      S_ACC_CHK: cmd_o.ovf_set = acc_en_i && sts_i.cnt_full;
      S_ACC_EX: begin
        cmd_o.sum_wr = 1'b1;
        cmd_o.cnt_wr = last_d;
      end
      S_UPD_DIV:  cmd_o.div_start = 1'b1;
      S_UPD_WAIT: cmd_o.cent_upd  = sts_i.div_done;
      S_PUT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.rows_clr = sts_i.out_free && kind_q == KIND_UPDATE;
      end
      default: cmd_o.rd = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      c_q     <= '0;
      d_q     <= '0;
      pos_q   <= '0;
      kind_q  <= KIND_ASSIGN;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_e'(in_i.opcode))
              OP_POINT: begin
                if (last_pt) begin
                  pos_q   <= '0;
                  c_q     <= '0;
                  d_q     <= '0;
                  state_q <= S_DIST_RD;
                end else begin
                  pos_q <= pos_q + DM_W'(1);
                end
              end
              OP_UPDATE: begin
                c_q     <= '0;
                d_q     <= '0;
                kind_q  <= KIND_UPDATE;
                state_q <= S_UPD_CNT_RD;
              end
              OP_READ: begin
                kind_q  <= KIND_READ;
                state_q <= S_PUT;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DIST_RD: state_q <= S_DIST_EX;
        S_DIST_EX: begin
          if (last_d) begin
            state_q <= S_DIST_CMP;
          end else begin
            d_q     <= d_q + DM_W'(1);
            state_q <= S_DIST_RD;
          end
        end
        S_DIST_CMP: begin
          d_q <= '0;
          if (last_c) begin
            state_q <= S_ACC_CHK_RD;
          end else begin
            c_q     <= c_q + CL_W'(1);
            state_q <= S_DIST_RD;
          end
        end
        S_ACC_CHK_RD: begin
          c_q     <= sts_i.best_c;
          d_q     <= '0;
          state_q <= S_ACC_CHK;
        end
        S_ACC_CHK: begin
          kind_q  <= KIND_ASSIGN;
          state_q <= (!acc_en_i || sts_i.cnt_full) ? S_PUT : S_ACC_RD;
        end
        S_ACC_RD: state_q <= S_ACC_EX;
        S_ACC_EX: begin
          if (last_d) begin
            state_q <= S_PUT;
          end else begin
            d_q     <= d_q + DM_W'(1);
            state_q <= S_ACC_RD;
          end
        end
        S_UPD_CNT_RD: state_q <= S_UPD_CNT;
        S_UPD_CNT: begin
          d_q <= '0;
          if (!sts_i.cnt_zero) begin
            state_q <= S_UPD_RD;
          end else if (last_c) begin
            state_q <= S_PUT;
          end else begin
            c_q     <= c_q + CL_W'(1);
            state_q <= S_UPD_CNT_RD;
          end
        end
        S_UPD_RD:  state_q <= S_UPD_DIV;
        S_UPD_DIV: state_q <= S_UPD_WAIT;
        S_UPD_WAIT: begin
          if (sts_i.div_done) begin
            if (!last_d) begin
              d_q     <= d_q + DM_W'(1);
              state_q <= S_UPD_RD;
            end else if (last_c) begin
              state_q <= S_PUT;
            end else begin
              c_q     <= c_q + CL_W'(1);
              d_q     <= '0;
              state_q <= S_UPD_CNT_RD;
            end
          end
        end
        S_PUT: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/kmeans_assign_and_update.sv */
// Top level of the k-means assignment and update block: configuration
// registers plus the controller and datapath. Depends on kaa_pkg and kaa_if.
//
//   channel  direction  carries
//   cfg_i    in         index, data  (cluster count, point length, accumulate)
//   in_i     in         opcode, cluster_index, dim_index, value
//   out_o    out        result_kind, nearest_cluster, min_distance, cluster_label,
//                       any_changed, count_overflow, read_data
//
// Loads and non-final point bytes are taken while the controller stays idle; a read passes through the output state.
// For a final point byte, one shared subtract-square-add unit visits every coordinate of every
// active centroid. An update divides each coordinate sum of every non-empty cluster by its count
// in a one-bit-per-cycle divider.
// Reset needs no clearing pass; per-cluster valid bits and fill lengths stand for zero sums
// and counts.
// Input is held off while an item is in work, also while its result waits for the output register to free up.
module kmeans_assign_and_update (
  input  logic      clk_i,
  input  logic      rst_ni,
  kaa_cfg_if.sink   cfg_i,
  kaa_in_if.sink    in_i,
  kaa_out_if.source out_o
);
  import kaa_pkg::*;

  logic [CFG_W-1:0] nc_q, nd_q, clamp_c, clamp_d;
  logic             acc_en_q;
  cmd_t             cmd;
  sts_t             sts;

  // Zero acts as one, anything above the maximum as the maximum.
  assign clamp_c = (cfg_i.data == '0) ? CFG_W'(1) :
                   (cfg_i.data > CFG_W'(MAX_CLUSTERS)) ? CFG_W'(MAX_CLUSTERS) : cfg_i.data;
  assign clamp_d = (cfg_i.data == '0) ? CFG_W'(1) :
                   (cfg_i.data > CFG_W'(MAX_DIMS)) ? CFG_W'(MAX_DIMS) : cfg_i.data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q     <= NC_RESET;
      nd_q     <= ND_RESET;
      acc_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CLUSTERS: nc_q     <= clamp_c;
        CFG_DIMS:     nd_q     <= clamp_d;
        CFG_ACCUM:    acc_en_q <= cfg_i.data[0];
        default:      acc_en_q <= acc_en_q;
      endcase
    end
  end

  kaa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .nc_i     (nc_q),
    .nd_i     (nd_q),
    .acc_en_i (acc_en_q),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  kaa_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );
endmodule
